### hdl/xbr_pkg.sv
// ----------------------------------------------------------------------------
// xbr_pkg
// Shared types and constants for the bounded xoshiro random generator.
// ----------------------------------------------------------------------------
`default_nettype none

package xbr_pkg;

    localparam logic [63:0] SEED_RESET  = 64'h853C_49E6_748F_EA9B;
    localparam logic [63:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;
    localparam logic [63:0] OUT_MUL     = 64'h2545_F491_4F6C_DD1D;
    localparam logic [32:0] TWO_POW_32  = 33'h1_0000_0000;

    // request to the serial remainder unit
    typedef struct packed {
        logic        start;
        logic [32:0] dividend;
        logic [31:0] divisor;
    } rem_req_t;

    // response from the serial remainder unit
    typedef struct packed {
        logic        done;
        logic [31:0] rem;
    } rem_rsp_t;

endpackage

`default_nettype wire

### hdl/xbr_rem.sv
// ----------------------------------------------------------------------------
// xbr_rem
// Restoring serial remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module xbr_rem (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire xbr_pkg::rem_req_t req,
    output xbr_pkg::rem_rsp_t      rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] dvd_reg, dvd_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [31:0] rem_reg, rem_next;
    logic [32:0] trial;
    logic [32:0] diff;

    // one shift/subtract step
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[32]};
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = 32'd0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[31:0], 1'b0};
            rem_next = diff[32] ? trial[31:0] : diff[31:0];
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd32)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

    // remainder is always below a nonzero divisor
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (dvs_reg != 32'd0) |-> rem_reg < dvs_reg)
        else $error("remainder not below divisor");

    // done follows the last step
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("done without a running division");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !done_reg)
        else $error("busy and done together");

endmodule

`default_nettype wire

### hdl/xoshiro_bounded_random.sv
// ----------------------------------------------------------------------------
// xoshiro_bounded_random
// xoshiro256 generator with splitmix64 seeding, raw or bounded 32-bit draws.
// ----------------------------------------------------------------------------
// channel  | handshake               | payload
// input    | in_valid / in_stall     | mode, limit
// output   | out_valid / out_stall   | value
// seed     | seed_valid / seed_ready | seed
//
// Raw draw: S_DRAW, S_MUL (one 64-bit product as three 32x32 partial products),
// S_DRAW_OUT, then S_DONE loads the output register.
// Seeding on the first draw after reset or a seed write adds eight products, four words, zero check.
// Bounded draw: 2^32 mod limit, then raw draws until one is accepted, then the final
// remainder; all divides run through one shared serial remainder unit.
// Reset: generator words zero, seed register at its reset value, unseeded.
// in_stall is high while an item is in work; one finished beat may wait on
// out_stall in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module xoshiro_bounded_random (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic signed [31:0] limit,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      value,
    input  wire logic        seed_valid,
    output logic             seed_ready,
    input  wire logic [63:0] seed
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DIV_B      = 4'd1;
    localparam logic [3:0] S_SEED_ADD   = 4'd2;
    localparam logic [3:0] S_MUL        = 4'd3;
    localparam logic [3:0] S_SEED_MIX2  = 4'd4;
    localparam logic [3:0] S_SEED_STORE = 4'd5;
    localparam logic [3:0] S_SEED_ZERO  = 4'd6;
    localparam logic [3:0] S_DRAW       = 4'd7;
    localparam logic [3:0] S_DRAW_OUT   = 4'd8;
    localparam logic [3:0] S_DIV_R      = 4'd9;
    localparam logic [3:0] S_DONE       = 4'd10;

    logic [3:0]  state_reg, state_next;
    logic [3:0]  ret_reg, ret_next;
    logic [1:0]  mcnt_reg, mcnt_next;
    logic [1:0]  sidx_reg, sidx_next;
    logic        seeded_reg, seeded_next;
    logic [63:0] seed_reg, seed_next;
    logic [63:0] gen_reg [4];
    logic [63:0] gen_next [4];
    logic [63:0] acc_reg, acc_next;
    logic [63:0] ma_reg, ma_next;
    logic [63:0] mb_reg, mb_next;
    logic [63:0] prod_reg, prod_next;
    logic        mode_reg, mode_next;
    logic [31:0] n_reg, n_next;
    logic [31:0] brem_reg, brem_next;
    logic [31:0] res_reg, res_next;
    logic        ov_reg, ov_next;
    logic [31:0] val_reg, val_next;
    xbr_pkg::rem_req_t req_reg, req_next;
    xbr_pkg::rem_rsp_t rsp;

    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_p;
    logic [63:0] acc_add, z, s1x5, scr, t17, s2a, s3a, s1a, s0a;
    logic [32:0] rej_sum;
    logic        out_free;

    xbr_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_reg),
        .rsp   (rsp)
    );

    // shared 32x32 multiplier
    assign mul_x = (mcnt_reg == 2'd2) ? ma_reg[63:32] : ma_reg[31:0];
    assign mul_y = (mcnt_reg == 2'd1) ? mb_reg[63:32] : mb_reg[31:0];
    assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

    assign out_free   = !ov_reg || !out_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign seed_ready = 1'b1;
    assign out_valid  = ov_reg;
    assign value      = val_reg;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        mcnt_next   = mcnt_reg;
        sidx_next   = sidx_reg;
        seeded_next = seeded_reg;
        seed_next   = seed_reg;
        for (int i = 0; i < 4; i++)
        begin
            gen_next[i] = gen_reg[i];
        end
        acc_next  = acc_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        prod_next = prod_reg;
        mode_next = mode_reg;
        n_next    = n_reg;
        brem_next = brem_reg;
        res_next  = res_reg;
        ov_next   = ov_reg && out_stall;
        val_next  = val_reg;
        req_next  = '{start: 1'b0, dividend: req_reg.dividend, divisor: req_reg.divisor};

        acc_add = acc_reg + xbr_pkg::GOLDEN_STEP;
        z       = prod_reg;
        s1x5    = gen_reg[1] + {gen_reg[1][61:0], 2'b00};
        scr     = {s1x5[56:0], s1x5[63:57]};
        t17     = {gen_reg[1][46:0], 17'd0};
        s2a     = gen_reg[2] ^ gen_reg[0];
        s3a     = gen_reg[3] ^ gen_reg[1];
        s1a     = gen_reg[1] ^ s2a;
        s0a     = gen_reg[0] ^ s3a;
        rej_sum = {1'b0, prod_reg[63:32]} + {1'b0, brem_reg};

        if (seed_valid)
        begin
            seed_next   = seed;
            seeded_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next = mode;
                    n_next    = limit;
                    sidx_next = 2'd0;
                    acc_next  = seed_reg;
                    if (mode && ((limit == 32'sd0) || limit[31]))
                    begin
                        res_next   = 32'd0;
                        state_next = S_DONE;
                    end
                    else if (mode)
                    begin
                        req_next   = '{start: 1'b1, dividend: xbr_pkg::TWO_POW_32,
                                       divisor: limit};
                        state_next = S_DIV_B;
                    end
                    else
                    begin
                        state_next = seeded_reg ? S_DRAW : S_SEED_ADD;
                    end
                end
            end
            S_DIV_B:
            begin
                if (rsp.done)
                begin
                    brem_next  = rsp.rem;
                    state_next = seeded_reg ? S_DRAW : S_SEED_ADD;
                end
            end
            S_SEED_ADD:
            begin
                acc_next   = acc_add;
                ma_next    = acc_add ^ (acc_add >> 30);
                mb_next    = xbr_pkg::MIX_MUL_A;
                ret_next   = S_SEED_MIX2;
                mcnt_next  = 2'd0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // low product, then the two cross terms into the upper half
                unique case (mcnt_reg)
                    2'd0:    prod_next = mul_p;
                    default: prod_next = {prod_reg[63:32] + mul_p[31:0], prod_reg[31:0]};
                endcase
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd2)
                begin
                    mcnt_next  = 2'd0;
                    state_next = ret_reg;
                end
            end
            S_SEED_MIX2:
            begin
                ma_next    = z ^ (z >> 27);
                mb_next    = xbr_pkg::MIX_MUL_B;
                ret_next   = S_SEED_STORE;
                mcnt_next  = 2'd0;
                state_next = S_MUL;
            end
            S_SEED_STORE:
            begin
                gen_next[sidx_reg] = z ^ (z >> 31);
                sidx_next          = sidx_reg + 2'd1;
                state_next         = (sidx_reg == 2'd3) ? S_SEED_ZERO : S_SEED_ADD;
            end
            S_SEED_ZERO:
            begin
                if ((gen_reg[0] | gen_reg[1] | gen_reg[2] | gen_reg[3]) == 64'd0)
                begin
                    gen_next[0] = 64'd1;
                end
                seeded_next = 1'b1;
                state_next  = S_DRAW;
            end
            S_DRAW:
            begin
                // scramble from word1, then advance the state
                ma_next     = scr;
                mb_next     = xbr_pkg::OUT_MUL;
                gen_next[0] = s0a;
                gen_next[1] = s1a;
                gen_next[2] = s2a ^ t17;
                gen_next[3] = {s3a[18:0], s3a[63:19]};
                ret_next    = S_DRAW_OUT;
                mcnt_next   = 2'd0;
                state_next  = S_MUL;
            end
            S_DRAW_OUT:
            begin
                if (!mode_reg)
                begin
                    res_next   = prod_reg[63:32];
                    state_next = S_DONE;
                end
                else if (rej_sum[32])
                begin
                    state_next = S_DRAW;
                end
                else
                begin
                    req_next   = '{start: 1'b1, dividend: {1'b0, prod_reg[63:32]},
                                   divisor: n_reg};
                    state_next = S_DIV_R;
                end
            end
            S_DIV_R:
            begin
                if (rsp.done)
                begin
                    res_next   = rsp.rem;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    val_next   = res_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            mcnt_reg   <= 2'd0;
            sidx_reg   <= 2'd0;
            seeded_reg <= 1'b0;
            seed_reg   <= xbr_pkg::SEED_RESET;
            for (int i = 0; i < 4; i++)
            begin
                gen_reg[i] <= 64'd0;
            end
            ov_reg  <= 1'b0;
            req_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            mcnt_reg   <= mcnt_next;
            sidx_reg   <= sidx_next;
            seeded_reg <= seeded_next;
            seed_reg   <= seed_next;
            for (int i = 0; i < 4; i++)
            begin
                gen_reg[i] <= gen_next[i];
            end
            ov_reg  <= ov_next;
            req_reg <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg          <= acc_next;
        ma_reg           <= ma_next;
        mb_reg           <= mb_next;
        prod_reg         <= prod_next;
        mode_reg         <= mode_next;
        n_reg            <= n_next;
        brem_reg         <= brem_next;
        res_reg          <= res_next;
        val_reg          <= val_next;
    end

    // a draw never starts from an all-zero state
    a_state_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRAW |-> (gen_reg[0] | gen_reg[1] | gen_reg[2] | gen_reg[3]) != 64'd0)
        else $error("draw from zero state");

    // bounded result stays below the limit
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && mode_reg && !n_reg[31] && n_reg != 32'd0
        |-> res_reg < n_reg)
        else $error("bounded result out of range");

    // a draw only happens once seeded
    a_seeded_draw: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRAW |-> seeded_reg)
        else $error("draw before seeding");

endmodule

`default_nettype wire

### bench/xoshiro_bounded_random_chk.sv
// ----------------------------------------------------------------------------
// xoshiro_bounded_random_chk
// Watches the input, output and seed channels of the bounded xoshiro
// generator, predicts each output beat from its own copy of the generator
// state, and counts mismatches for the testbench top.
// ----------------------------------------------------------------------------
module xoshiro_bounded_random_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        mode,
    input  logic [31:0] limit,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] value,
    input  logic        seed_valid,
    input  logic        seed_ready,
    input  logic [63:0] seed,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0] seed_reg;
    logic [63:0] gen_word [4];
    bit          gen_seeded;
    logic [31:0] value_q [$];

    assign pending = value_q.size();

    function automatic logic [63:0] rotl64(logic [63:0] v, int k);
        return (v << k) | (v >> (64 - k));
    endfunction

    function automatic logic [63:0] splitmix(ref logic [63:0] acc);
        logic [63:0] z;
        acc = acc + xbr_pkg::GOLDEN_STEP;
        z = acc;
        z = (z ^ (z >> 30)) * xbr_pkg::MIX_MUL_A;
        z = (z ^ (z >> 27)) * xbr_pkg::MIX_MUL_B;
        return z ^ (z >> 31);
    endfunction

    // one raw word, seeding first if needed, then advance the state
    function automatic logic [31:0] next_word();
        logic [63:0]  acc;
        logic [63:0]  scr;
        logic [63:0]  t;
        logic [127:0] prod;
        if (!gen_seeded)
        begin
            acc = seed_reg;
            for (int i = 0; i < 4; i++)
                gen_word[i] = splitmix(acc);
            if ((gen_word[0] | gen_word[1] | gen_word[2] | gen_word[3]) == 64'd0)
                gen_word[0] = 64'd1;
            gen_seeded = 1'b1;
        end
        scr = rotl64(gen_word[1] * 64'd5, 7);
        t = gen_word[1] << 17;
        gen_word[2] ^= gen_word[0];
        gen_word[3] ^= gen_word[1];
        gen_word[1] ^= gen_word[2];
        gen_word[0] ^= gen_word[3];
        gen_word[2] ^= t;
        gen_word[3] = rotl64(gen_word[3], 45);
        prod = scr * xbr_pkg::OUT_MUL;
        return prod[63:32];
    endfunction

    function automatic logic [31:0] predict_value(logic m, logic [31:0] lim);
        logic [32:0] bound;
        logic [32:0] r;
        if (!m)
            return next_word();
        if (lim == 32'd0 || lim[31])
            return 32'd0;
        bound = (xbr_pkg::TWO_POW_32 / {1'b0, lim}) * {1'b0, lim};
        do
            r = {1'b0, next_word()};
        while (r >= bound);
        return 32'(r % {1'b0, lim});
    endfunction

    // track accepted beats on every channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   = xbr_pkg::SEED_RESET;
            gen_word   = '{default: 64'd0};
            gen_seeded = 1'b0;
            value_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (seed_valid && seed_ready)
            begin
                seed_reg   = seed;
                gen_seeded = 1'b0;
            end
            if (in_valid && !in_stall)
                value_q.push_back(predict_value(mode, limit));
            if (out_valid && !out_stall)
            begin
                if (value_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected output beat value=%h", value);
                end
                else if (value_q[0] !== value)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("value mismatch exp=%h act=%h", value_q[0], value);
                    void'(value_q.pop_front());
                end
                else
                    void'(value_q.pop_front());
            end
        end
    end
endmodule

### bench/xoshiro_bounded_random_tb.sv
// ----------------------------------------------------------------------------
// xoshiro_bounded_random_tb
// Drives raw and bounded draws through the generator under several seeds,
// with random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module xoshiro_bounded_random_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM   = 1700;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        mode = 1'b0;
    logic [31:0] limit = '0;
    logic        out_stall = 1'b0;
    logic        seed_valid = 1'b0;
    logic [63:0] seed = '0;
    logic        in_stall, out_valid, seed_ready;
    logic [31:0] value;
    int          fail_count, pending;
    bit          quiet_tail = 1'b0;
    bit          hold_req = 1'b0;
    int          idle_cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    xoshiro_bounded_random u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .limit(limit),
        .out_valid(out_valid), .out_stall(out_stall), .value(value),
        .seed_valid(seed_valid), .seed_ready(seed_ready), .seed(seed)
    );

    xoshiro_bounded_random_chk u_chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .limit(limit),
        .out_valid(out_valid), .out_stall(out_stall), .value(value),
        .seed_valid(seed_valid), .seed_ready(seed_ready), .seed(seed),
        .fail_count(fail_count), .pending(pending)
    );

    // watchdog: cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
            || (seed_valid && seed_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL xoshiro_bounded_random");
            $finish;
        end
    end

    // receiver: random stall bursts, or one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (300) @(negedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // one beat on the input channel, sometimes with a random gap before it
    task automatic send_draw(logic m, logic [31:0] lim);
        bit accepted;
        if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        limit    <= lim;
        // in_stall only moves on rising edges, so its value here holds
        // through the coming edge
        accepted = 1'b0;
        while (!accepted)
        begin
            accepted = !in_stall;
            @(negedge clk);
        end
    endtask

    // seed write while idle
    task automatic write_seed(logic [63:0] s);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        seed_valid <= 1'b1;
        seed       <= s;
        @(posedge clk);
        while (!seed_ready) @(posedge clk);
        @(negedge clk);
        seed_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_limit();
        case ($urandom_range(0, 9))
            0: return 32'd1 << $urandom_range(0, 30);
            1: return $urandom_range(1, 16);
            2: return {1'b1, 31'($urandom())};
            3: return 32'd0;
            4: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            5: return (32'd1 << $urandom_range(30, 31)) + $urandom_range(0, 99);
            default: return {1'b0, 31'($urandom())};
        endcase
    endfunction

    initial
    begin
        logic [31:0] lim;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: raw draws, bound extremes, nonpositive, powers of two
        send_draw(1'b1, 32'd0);
        send_draw(1'b1, 32'h8000_0000);
        send_draw(1'b1, 32'hFFFF_FFFF);
        send_draw(1'b0, 32'hFFFF_FFFF);
        send_draw(1'b0, 32'd0);
        send_draw(1'b1, 32'd1);
        send_draw(1'b1, 32'd2);
        send_draw(1'b1, 32'd3);
        send_draw(1'b1, 32'h4000_0000);
        send_draw(1'b1, 32'h4000_0001);
        send_draw(1'b1, 32'h7FFF_FFFF);
        send_draw(1'b1, 32'h5555_5555);
        send_draw(1'b1, 32'h0000_FFFF);

        // seed extremes, including a seed whose fill could be all zero
        write_seed(64'd0);
        send_draw(1'b1, 32'd0);
        send_draw(1'b0, 32'd0);
        send_draw(1'b1, 32'd7);
        write_seed(64'hFFFF_FFFF_FFFF_FFFF);
        send_draw(1'b0, 32'd0);
        send_draw(1'b1, 32'd100);
        write_seed(64'h61C8_8646_80B5_83EB);
        send_draw(1'b0, 32'd0);

        // fill the block while the receiver holds off
        hold_req = 1'b1;
        for (int i = 0; i < 8; i++)
            send_draw(i[0], 32'd10 + i);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 400 == 399)
                write_seed({$urandom(), $urandom()});
            if (i == N_RANDOM - 200)
                quiet_tail = 1'b1;
            lim = rand_limit();
            send_draw(1'($urandom_range(0, 2) != 0), lim);
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0)
            $display("PASS xoshiro_bounded_random");
        else
            $display("FAIL xoshiro_bounded_random");
        $finish;
    end
endmodule
